// ===== rtl/core/aapd_pkg.sv =====
// ----------------------------------------------------------------------------
// aapd_pkg
// Types, constants and helpers shared by the airbrake apogee controller.
// ----------------------------------------------------------------------------
package aapd_pkg;

  // divider geometry: widest dividend is gsum << 56, widest divisor is v^2
  localparam int unsigned DIV_NW = 103;
  localparam int unsigned DIV_DW = 63;
  localparam int unsigned DIV_CW = $clog2(DIV_NW);

  // configuration register indexes
  localparam logic [2:0] REG_SOS    = 3'd0;
  localparam logic [2:0] REG_MASS   = 3'd1;
  localparam logic [2:0] REG_AREA   = 3'd2;
  localparam logic [2:0] REG_GRAV   = 3'd3;
  localparam logic [2:0] REG_ZETA   = 3'd4;
  localparam logic [2:0] REG_TARGET = 3'd5;
  localparam logic [2:0] REG_FLOOR  = 3'd6;

  localparam logic [25:0] SOS_RST    = 26'd22478848;
  localparam logic [25:0] MASS_RST   = 26'd1310720;
  localparam logic [16:0] AREA_RST   = 17'd655;
  localparam logic [20:0] GRAV_RST   = 21'd642908;
  localparam logic [18:0] ZETA_RST   = 19'd46341;
  localparam logic [30:0] TARGET_RST = 31'd200540160;
  localparam logic [17:0] FLOOR_RST  = 18'd6554;

  localparam logic [61:0] SAT_CAP    = '1;
  localparam logic [15:0] ANGLE_STOW = 16'd46080;
  localparam logic [16:0] MACH_LO    = 17'd19661;
  localparam logic [16:0] MACH_HI    = 17'd72090;
  localparam logic [16:0] DEPLOY_MAX = 17'd65536;
  localparam logic [31:0] ACCEL_LIM  = 32'd3276800;
  localparam logic [25:0] KELVIN_Q16 = 26'd17901158;
  localparam logic [63:0] GAS_R_Q16  = 64'd18812633;
  localparam logic [31:0] ANGLE_SPAN = 32'd42240;
  localparam logic [31:0] ROUND_HALF = 32'd32768;
  localparam logic [31:0] DT_DEFAULT = 32'd20;
  localparam logic [DIV_NW-1:0] DRAG_CAP = DIV_NW'(64'd1 << 46);
  localparam logic [DIV_NW-1:0] TERM_CAP = DIV_NW'(64'd1 << 47);

  // drag polynomial, Q2.30 coefficients
  localparam logic [63:0] POLY_A1 = 64'd21152714;
  localparam logic [63:0] POLY_A2 = 64'd42305428;
  localparam logic [63:0] POLY_A3 = 64'd26414049;
  localparam logic [63:0] POLY_B1 = 64'd9234180;
  localparam logic [63:0] POLY_B2 = 64'd19219979;
  localparam logic [63:0] POLY_B3 = 64'd12670154;
  localparam logic signed [63:0] POLY_A0 = -(64'sd2899103 * 64'sd65536);
  localparam logic signed [63:0] POLY_B0 = 64'sd3758096 * 64'sd65536;
  localparam logic signed [63:0] CD_BASE = 64'sd1844674407370955162;

  typedef enum logic [4:0] {
    S_IDLE, S_RK, S_RHO, S_MACH, S_M2, S_M3, S_D2,
    S_A1, S_A2, S_A3, S_AD, S_B1, S_B2, S_B3, S_BD,
    S_KC1, S_KC2, S_V2, S_KV, S_DRAG, S_TERM, S_H, S_H2,
    S_NM, S_KP, S_KD, S_ERR, S_RMAG, S_PM, S_DM, S_FIN
  } seq_state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  function automatic logic [61:0] sat62(input logic [127:0] v);
    return (v[127:62] != '0) ? SAT_CAP : v[61:0];
  endfunction

endpackage

// ===== rtl/core/airbrake_apogee_pd_controller.sv =====
// ----------------------------------------------------------------------------
// airbrake_apogee_pd_controller
// Gain-scheduled PD controller on predicted apogee error for an airbrake
// servo, built around a shared multiplier and a shared divider.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------
//  in      | in_valid_i / in_stall_o    | pressure .. accel_x
//  out     | out_valid_o / out_stall_i  | gain_p, gain_d, angles, gate_open
//  cfg     | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// one item at a time: products and quotients run one after another
// slow vehicle: about 14 products and 1-2 quotients
// normal flight: 21 products and 6-7 quotients
// the finished item sits in the output register so a new item can start
// reset puts the registers at their defaults and clears the history
// ----------------------------------------------------------------------------
module airbrake_apogee_pd_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [24:0] pressure_i,
  input  logic [23:0] temperature_i,
  input  logic [31:0] altitude_i,
  input  logic [31:0] velocity_i,
  input  logic [31:0] tick_ms_i,
  input  logic        active_i,
  input  logic [31:0] accel_x_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] gain_p_o,
  output logic [47:0] gain_d_o,
  output logic [15:0] computed_angle_o,
  output logic [15:0] applied_angle_o,
  output logic        gate_open_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i
);
  import aapd_pkg::*;

  seq_state_e state_q, state_d;
  logic       iss_q, op_mul, op_div, op_done, accept;
  mul_req_t   mreq;
  div_req_t   dreq;
  logic       mul_done, div_done;
  logic [127:0]      mul_p;
  logic [DIV_NW-1:0] div_q;

  // configuration
  logic [25:0] sos_q, mass_q;
  logic [16:0] area_q;
  logic [20:0] grav_q;
  logic [18:0] zeta_q;
  logic [30:0] target_q;
  logic [17:0] floor_q;

  // history
  logic [31:0] last_tick_q, last_error_q;
  logic [16:0] last_deploy_q;

  // item and working registers
  logic [24:0] pres_q;
  logic [23:0] temp_q;
  logic [31:0] alt_q, vabs_q, dt_q;
  logic        vpos_q, gate_q;
  logic [33:0] rk_q;
  logic [25:0] rho_q;
  logic [16:0] mach_q, m2_q, m3_q, d2_q;
  logic signed [63:0] acc_q, tot_q;
  logic [61:0] tmp_q, kc_q, h_q, h2_q, nm_q, kp_q, kd_q, pmag_q, dmag_q;
  logic [62:0] v2_q;
  logic [46:0] gsum_q;
  logic [47:0] term_q;
  logic [31:0] err_q;
  logic [32:0] diff_q;
  logic [42:0] rmag_q;

  logic        out_valid_q, gate_open_q;
  logic [47:0] gain_p_q, gain_d_q;
  logic [15:0] comp_q, appl_q;

  // combinational helpers
  logic [31:0] vabs_in, dt_raw, ax_abs;
  logic [25:0] temp_k;
  logic [63:0] acc_abs;
  logic [17:0] cd_w;
  logic [49:0] err_full;
  logic [31:0] err_w, eabs;
  logic [32:0] diff_w, dabs;
  logic [42:0] dnum;
  logic [16:0] mach_w;
  logic [61:0] kq;
  logic signed [63:0] pv, dv, outv;
  logic [16:0] deploy_w;
  logic [31:0] ang_prod;
  logic [15:0] ang_w;
  logic        slow, fin_go;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign slow       = (vabs_q[31:16] == '0);
  assign fin_go     = !out_valid_q || !out_stall_i;

  assign vabs_in = velocity_i[31] ? 32'(-velocity_i) : velocity_i;
  assign dt_raw  = tick_ms_i - last_tick_q;
  assign ax_abs  = accel_x_i[31] ? 32'(-accel_x_i) : accel_x_i;
  assign temp_k  = {{2{temp_q[23]}}, temp_q} + KELVIN_Q16;
  assign acc_abs = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  assign cd_w    = (tot_q[63:46] < floor_q) ? floor_q : tot_q[63:46];

  // apogee error, saturated to 32 bits
  assign err_full = {{18{alt_q[31]}}, alt_q} + {2'b0, term_q} - {19'b0, target_q};
  always_comb begin
    if ((err_full[49:31] == '0) || (err_full[49:31] == '1)) begin
      err_w = err_full[31:0];
    end else begin
      err_w = err_full[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end
  assign diff_w = {err_w[31], err_w} - {last_error_q[31], last_error_q};
  assign eabs   = err_q[31] ? 32'(-err_q) : err_q;
  assign dabs   = diff_q[32] ? 33'(-diff_q) : diff_q;
  // x*1000 = x*1024 - x*16 - x*8
  assign dnum   = ({10'b0, dabs} << 10) - ({10'b0, dabs} << 4) - ({10'b0, dabs} << 3);

  always_comb begin
    if ((div_q[DIV_NW-1:17] != '0) || (div_q[16:0] > MACH_HI)) begin
      mach_w = MACH_HI;
    end else if (div_q[16:0] < MACH_LO) begin
      mach_w = MACH_LO;
    end else begin
      mach_w = div_q[16:0];
    end
  end
  assign kq = sat62(128'(div_q));

  // deployment and angle
  assign pv   = err_q[31] ? -$signed({2'b0, pmag_q}) : $signed({2'b0, pmag_q});
  assign dv   = diff_q[32] ? -$signed({2'b0, dmag_q}) : $signed({2'b0, dmag_q});
  assign outv = pv + dv;
  always_comb begin
    if (outv[63]) begin
      deploy_w = '0;
    end else if (outv > 64'sd65536) begin
      deploy_w = DEPLOY_MAX;
    end else begin
      deploy_w = outv[16:0];
    end
  end
  assign ang_prod = {15'b0, deploy_w} * ANGLE_SPAN + ROUND_HALF;
  assign ang_w    = slow ? ANGLE_STOW : ANGLE_STOW - ang_prod[31:16];

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_RK;
      S_RK:    if (op_done) state_d = S_RHO;
      S_RHO:   if (op_done) state_d = vpos_q ? S_MACH : S_M2;
      S_MACH:  if (op_done) state_d = S_M2;
      S_M2:    if (op_done) state_d = S_M3;
      S_M3:    if (op_done) state_d = S_D2;
      S_D2:    if (op_done) state_d = S_A1;
      S_A1:    if (op_done) state_d = S_A2;
      S_A2:    if (op_done) state_d = S_A3;
      S_A3:    if (op_done) state_d = S_AD;
      S_AD:    if (op_done) state_d = S_B1;
      S_B1:    if (op_done) state_d = S_B2;
      S_B2:    if (op_done) state_d = S_B3;
      S_B3:    if (op_done) state_d = S_BD;
      S_BD:    if (op_done) state_d = S_KC1;
      S_KC1:   if (op_done) state_d = S_KC2;
      S_KC2:   if (op_done) state_d = slow ? S_FIN : S_V2;
      S_V2:    if (op_done) state_d = S_KV;
      S_KV:    if (op_done) state_d = S_DRAG;
      S_DRAG:  if (op_done) state_d = S_TERM;
      S_TERM:  if (op_done) state_d = S_H;
      S_H:     if (op_done) state_d = S_H2;
      S_H2:    if (op_done) state_d = S_NM;
      S_NM:    if (op_done) state_d = S_KP;
      S_KP:    if (op_done) state_d = S_KD;
      S_KD:    if (op_done) state_d = S_ERR;
      S_ERR:   state_d = S_RMAG;
      S_RMAG:  if (op_done) state_d = S_PM;
      S_PM:    if (op_done) state_d = S_DM;
      S_DM:    if (op_done) state_d = S_FIN;
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- sequencer: unit operands ----------------
  always_comb begin
    op_mul = 1'b0;
    op_div = 1'b0;
    mreq   = '0;
    dreq   = '0;
    unique case (state_q)
      S_RK:   begin op_mul = 1'b1; mreq.a = 64'(temp_k[24:0]); mreq.b = GAS_R_Q16; end
      S_RHO:  begin op_div = 1'b1; dreq.num = DIV_NW'({pres_q, 32'b0});
                    dreq.den = DIV_DW'(rk_q); end
      S_MACH: begin op_div = 1'b1; dreq.num = DIV_NW'({vabs_q, 16'b0});
                    dreq.den = DIV_DW'(sos_q); end
      S_M2:   begin op_mul = 1'b1; mreq.a = 64'(mach_q); mreq.b = 64'(mach_q); end
      S_M3:   begin op_mul = 1'b1; mreq.a = 64'(m2_q); mreq.b = 64'(mach_q); end
      S_D2:   begin op_mul = 1'b1; mreq.a = 64'(last_deploy_q); mreq.b = 64'(last_deploy_q); end
      S_A1:   begin op_mul = 1'b1; mreq.a = POLY_A1; mreq.b = 64'(mach_q); end
      S_A2:   begin op_mul = 1'b1; mreq.a = POLY_A2; mreq.b = 64'(m2_q); end
      S_A3:   begin op_mul = 1'b1; mreq.a = POLY_A3; mreq.b = 64'(m3_q); end
      S_AD:   begin op_mul = 1'b1; mreq.a = acc_abs; mreq.b = 64'(last_deploy_q); end
      S_B1:   begin op_mul = 1'b1; mreq.a = POLY_B1; mreq.b = 64'(mach_q); end
      S_B2:   begin op_mul = 1'b1; mreq.a = POLY_B2; mreq.b = 64'(m2_q); end
      S_B3:   begin op_mul = 1'b1; mreq.a = POLY_B3; mreq.b = 64'(m3_q); end
      S_BD:   begin op_mul = 1'b1; mreq.a = acc_abs; mreq.b = 64'(d2_q); end
      S_KC1:  begin op_mul = 1'b1; mreq.a = 64'(rho_q); mreq.b = 64'(cd_w); end
      S_KC2:  begin op_mul = 1'b1; mreq.a = 64'(tmp_q); mreq.b = 64'(area_q); end
      S_V2:   begin op_mul = 1'b1; mreq.a = 64'(vabs_q); mreq.b = 64'(vabs_q); end
      S_KV:   begin op_mul = 1'b1; mreq.a = 64'(kc_q); mreq.b = 64'(v2_q); end
      S_DRAG: begin op_div = 1'b1; dreq.num = DIV_NW'(tmp_q);
                    dreq.den = DIV_DW'({mass_q, 1'b0}); end
      S_TERM: begin op_div = 1'b1; dreq.num = DIV_NW'(v2_q);
                    dreq.den = DIV_DW'({gsum_q, 1'b0}); end
      S_H:    begin op_div = 1'b1; dreq.num = {gsum_q, 56'b0}; dreq.den = v2_q; end
      S_H2:   begin op_mul = 1'b1; mreq.a = 64'(h_q); mreq.b = 64'(h_q); end
      S_NM:   begin op_mul = 1'b1; mreq.a = 64'(mass_q); mreq.b = 64'(h2_q); end
      S_KP:   begin op_div = 1'b1; dreq.num = DIV_NW'({nm_q, 24'b0});
                    dreq.den = DIV_DW'(kc_q); end
      S_KD:   begin op_mul = 1'b1; mreq.a = 64'(kp_q); mreq.b = 64'(zeta_q); end
      S_RMAG: begin op_div = 1'b1; dreq.num = DIV_NW'(dnum); dreq.den = DIV_DW'(dt_q); end
      S_PM:   begin op_mul = 1'b1; mreq.a = 64'(kp_q); mreq.b = 64'(eabs); end
      S_DM:   begin op_mul = 1'b1; mreq.a = 64'(kd_q); mreq.b = 64'(rmag_q); end
      default: begin
        op_mul = 1'b0;
        op_div = 1'b0;
      end
    endcase
    mreq.start = op_mul && !iss_q;
    dreq.start = op_div && !iss_q;
  end

  assign op_done = (op_mul && mul_done) || (op_div && div_done);

  aapd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  aapd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .done_o (div_done),
    .quot_o (div_q)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      iss_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      sos_q         <= SOS_RST;
      mass_q        <= MASS_RST;
      area_q        <= AREA_RST;
      grav_q        <= GRAV_RST;
      zeta_q        <= ZETA_RST;
      target_q      <= TARGET_RST;
      floor_q       <= FLOOR_RST;
      last_tick_q   <= '0;
      last_error_q  <= '0;
      last_deploy_q <= '0;
    end else begin
      state_q <= state_d;
      if (op_done) begin
        iss_q <= 1'b0;
      end else if (mreq.start || dreq.start) begin
        iss_q <= 1'b1;
      end
      if (state_q == S_FIN && fin_go) begin
        out_valid_q <= 1'b1;
        if (!slow) begin
          last_error_q  <= err_q;
          last_deploy_q <= deploy_w;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        last_tick_q <= tick_ms_i;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SOS:    sos_q    <= cfg_data_i[25:0];
          REG_MASS:   mass_q   <= cfg_data_i[25:0];
          REG_AREA:   area_q   <= cfg_data_i[16:0];
          REG_GRAV:   grav_q   <= cfg_data_i[20:0];
          REG_ZETA:   zeta_q   <= cfg_data_i[18:0];
          REG_TARGET: target_q <= cfg_data_i[30:0];
          REG_FLOOR:  floor_q  <= cfg_data_i[17:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pres_q <= pressure_i;
      temp_q <= temperature_i;
      alt_q  <= altitude_i;
      vabs_q <= vabs_in;
      vpos_q <= !velocity_i[31] && (velocity_i != '0);
      dt_q   <= (dt_raw == '0) ? DT_DEFAULT : dt_raw;
      gate_q <= active_i && (ax_abs <= ACCEL_LIM);
      mach_q <= MACH_LO;
    end
    if (state_q == S_ERR) begin
      err_q  <= err_w;
      diff_q <= diff_w;
    end
    if (op_done) begin
      unique case (state_q)
        S_RK:   rk_q   <= mul_p[49:16];
        S_RHO:  rho_q  <= div_q[25:0];
        S_MACH: mach_q <= mach_w;
        S_M2:   m2_q   <= mul_p[32:16];
        S_M3:   m3_q   <= mul_p[32:16];
        S_D2:   d2_q   <= mul_p[32:16];
        S_A1:   acc_q  <= POLY_A0 + $signed(mul_p[63:0]);
        S_A2:   acc_q  <= acc_q - $signed(mul_p[63:0]);
        S_A3:   acc_q  <= acc_q + $signed(mul_p[63:0]);
        S_AD:   tot_q  <= acc_q[63] ? CD_BASE - $signed(mul_p[63:0])
                                    : CD_BASE + $signed(mul_p[63:0]);
        S_B1:   acc_q  <= POLY_B0 - $signed(mul_p[63:0]);
        S_B2:   acc_q  <= acc_q + $signed(mul_p[63:0]);
        S_B3:   acc_q  <= acc_q - $signed(mul_p[63:0]);
        S_BD:   tot_q  <= acc_q[63] ? tot_q - $signed(mul_p[63:0])
                                    : tot_q + $signed(mul_p[63:0]);
        S_KC1:  tmp_q  <= sat62(mul_p >> 8);
        S_KC2:  kc_q   <= sat62(mul_p >> 16);
        S_V2:   v2_q   <= mul_p[62:0];
        S_KV:   tmp_q  <= sat62(mul_p >> 32);
        S_DRAG: gsum_q <= 47'(grav_q) + ((div_q > DRAG_CAP) ? DRAG_CAP[46:0] : div_q[46:0]);
        S_TERM: term_q <= (div_q > TERM_CAP) ? TERM_CAP[47:0] : div_q[47:0];
        S_H:    h_q    <= kq;
        S_H2:   h2_q   <= sat62(mul_p >> 40);
        S_NM:   nm_q   <= sat62(mul_p >> 16);
        // scale by four, saturating
        S_KP:   kp_q   <= (kq[61:60] != '0) ? SAT_CAP : {kq[59:0], 2'b0};
        S_KD:   kd_q   <= sat62(mul_p >> 15);
        S_RMAG: rmag_q <= div_q[42:0];
        S_PM:   pmag_q <= sat62(mul_p >> 32);
        S_DM:   dmag_q <= sat62(mul_p >> 32);
        default: ;
      endcase
    end
    if (state_q == S_FIN && fin_go) begin
      gain_p_q    <= slow ? '0 : {2'b0, kp_q[61:16]};
      gain_d_q    <= slow ? '0 : {2'b0, kd_q[61:16]};
      comp_q      <= ang_w;
      appl_q      <= gate_q ? ang_w : ANGLE_STOW;
      gate_open_q <= gate_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign gain_p_o         = gain_p_q;
  assign gain_d_o         = gain_d_q;
  assign computed_angle_o = comp_q;
  assign applied_angle_o  = appl_q;
  assign gate_open_o      = gate_open_q;

endmodule

// ===== rtl/core/aapd_mul.sv =====
// ----------------------------------------------------------------------------
// aapd_mul
// 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module aapd_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aapd_pkg::mul_req_t req_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);
  import aapd_pkg::*;

  logic        busy_q, done_q;
  logic [2:0]  cnt_q;
  logic [63:0] a_q, b_q, pp_q;
  logic [1:0]  sh_q;
  logic [127:0] acc_q;
  logic [31:0] a_half, b_half;

  assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial product registered, accumulated in the cycle after
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q <= 64'(a_half) * 64'(b_half);
        sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + ({64'b0, pp_q} << {sh_q, 5'b0});
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/core/aapd_div.sv =====
// ----------------------------------------------------------------------------
// aapd_div
// Restoring divider, one quotient bit per cycle. A zero divisor yields
// an all-ones quotient.
// ----------------------------------------------------------------------------
module aapd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aapd_pkg::div_req_t            req_i,
  output logic                          done_o,
  output logic [aapd_pkg::DIV_NW-1:0]   quot_o
);
  import aapd_pkg::*;

  logic              busy_q, done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_NW-1:0] nq_q;
  logic [DIV_DW-1:0] rem_q, den_q;
  logic [DIV_DW:0]   rem_sh, rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, nq_q[DIV_NW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      nq_q  <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      nq_q  <= {nq_q[DIV_NW-2:0], ge};
      rem_q <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = nq_q;

endmodule

// ===== rtl/core/aapd_checker.sv =====
// ----------------------------------------------------------------------------
// aapd_checker
// Port-level checks for the airbrake apogee controller.
// ----------------------------------------------------------------------------
module aapd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] computed_angle_o,
  input logic [15:0] applied_angle_o,
  input logic        gate_open_o
);
  import aapd_pkg::*;

  // held item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took no time for an item");

  a_gate_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !gate_open_o |-> applied_angle_o == ANGLE_STOW)
    else $error("closed gate did not stow the brake");

  a_gate_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gate_open_o |-> applied_angle_o == computed_angle_o)
    else $error("open gate did not pass the computed angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> computed_angle_o >= 16'd3840 && computed_angle_o <= ANGLE_STOW)
    else $error("computed angle out of servo range");

endmodule

bind airbrake_apogee_pd_controller aapd_checker u_aapd_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the airbrake apogee PD controller. A scoreboard
// predicts gains and servo angles for every accepted item, holds them in
// order and compares them field by field with the block's results, across
// several register settings with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import aapd_pkg::*;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam int unsigned WDOG_LIMIT = 60000;
  localparam int unsigned TAIL_CYCLES = 1200;
  localparam int unsigned ITEMS_PER_PHASE = 205;
  localparam int unsigned NUM_PHASES = 8;

  typedef struct packed {
    logic [24:0] pres;
    logic [23:0] temp;
    logic [31:0] alt;
    logic [31:0] vel;
    logic [31:0] tick;
    logic        act;
    logic [31:0] ax;
  } sample_t;

  typedef struct packed {
    logic [47:0] kp;
    logic [47:0] kd;
    logic [15:0] ang;
    logic [15:0] app;
    logic        gate;
  } command_t;

  class brake_scoreboard;
    logic [63:0] cfg [7];
    logic [31:0] last_tick;
    int          last_error;
    logic [16:0] last_deploy;
    command_t    cmd_q [$];
    int unsigned errors;

    function new();
      cfg[0] = SOS_RST;  cfg[1] = MASS_RST; cfg[2] = AREA_RST; cfg[3] = GRAV_RST;
      cfg[4] = ZETA_RST; cfg[5] = TARGET_RST; cfg[6] = FLOOR_RST;
      last_tick = '0;
      last_error = 0;
      last_deploy = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [30:0] val);
      int w;
      case (idx)
        REG_SOS, REG_MASS: w = 26;
        REG_AREA:          w = 17;
        REG_GRAV:          w = 21;
        REG_ZETA:          w = 19;
        REG_TARGET:        w = 31;
        REG_FLOOR:         w = 18;
        default:           w = 0;
      endcase
      if (w != 0) cfg[idx] = 64'(val) & ((64'd1 << w) - 64'd1);
    endfunction

    function logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s, logic [63:0] cap);
      logic [127:0] p;
      p = ({64'b0, a} * {64'b0, b}) >> s;
      return (p > {64'b0, cap}) ? cap : p[63:0];
    endfunction

    function logic [63:0] div_shl(logic [63:0] num, logic [63:0] den, int s, logic [63:0] cap);
      logic [127:0] q;
      if (den == 0) return cap;
      q = ({64'b0, num} << s) / {64'b0, den};
      return (q > {64'b0, cap}) ? cap : q[63:0];
    endfunction

    function command_t predict(sample_t it);
      command_t    r;
      longint      temp, alt, vel, ax, a_sum, b_sum, tot, err, diff, pv, dv, outv;
      logic [63:0] vabs, rk, rho, mach, m2, m3, d, d2, cd, kc, cap, utot;
      logic [63:0] v2, adrag, gsum, term, h, h2, nm, kp, kd, eabs, rmag, pmag, dmag, angle;
      logic [31:0] dt;
      bit          gate;
      cap = 64'(SAT_CAP);
      temp = longint'($signed(it.temp));
      alt = longint'($signed(it.alt));
      vel = longint'($signed(it.vel));
      ax = longint'($signed(it.ax));
      vabs = (vel < 0) ? 64'(-vel) : 64'(vel);
      dt = it.tick - last_tick;
      last_tick = it.tick;
      if (dt == 0) dt = DT_DEFAULT;
      kp = 0;
      kd = 0;
      angle = 64'(ANGLE_STOW);

      rk = (GAS_R_Q16 * 64'(temp + longint'(KELVIN_Q16))) >> 16;
      rho = (64'(it.pres) << 32) / rk;
      if (vel <= 0) mach = 64'(MACH_LO);
      else mach = div_shl(vabs, cfg[0], 16, cap);
      if (mach < 64'(MACH_LO)) mach = 64'(MACH_LO);
      if (mach > 64'(MACH_HI)) mach = 64'(MACH_HI);
      m2 = (mach * mach) >> 16;
      m3 = (m2 * mach) >> 16;
      d = 64'(last_deploy);
      d2 = (d * d) >> 16;
      a_sum = POLY_A0 + longint'(POLY_A1) * longint'(mach)
            - longint'(POLY_A2) * longint'(m2) + longint'(POLY_A3) * longint'(m3);
      b_sum = POLY_B0 - longint'(POLY_B1) * longint'(mach)
            + longint'(POLY_B2) * longint'(m2) - longint'(POLY_B3) * longint'(m3);
      tot = CD_BASE + a_sum * longint'(d) + b_sum * longint'(d2);
      utot = tot;
      cd = utot >> 46;
      if (cd < cfg[6]) cd = cfg[6];
      kc = mul_shr(mul_shr(rho, cd, 8, cap), cfg[2], 16, cap);

      if (vabs >= 64'd65536) begin
        v2 = vabs * vabs;
        adrag = div_shl(mul_shr(kc, v2, 32, cap), 2 * cfg[1], 0, 64'd1 << 46);
        gsum = cfg[3] + adrag;
        term = div_shl(v2, 2 * gsum, 0, 64'd1 << 47);
        h = div_shl(gsum, v2, 56, cap);
        h2 = mul_shr(h, h, 40, cap);
        nm = mul_shr(cfg[1], h2, 16, cap);
        kp = div_shl(nm, kc, 24, cap);
        kp = (kp > (cap >> 2)) ? cap : (kp << 2);
        kd = mul_shr(kp, cfg[4], 15, cap);
        err = alt + longint'(term) - longint'(cfg[5]);
        if (err > 64'sd2147483647) err = 64'sd2147483647;
        if (err < -64'sd2147483648) err = -64'sd2147483648;
        diff = err - longint'(last_error);
        rmag = (64'((diff < 0) ? -diff : diff) * 64'd1000) / 64'(dt);
        eabs = 64'((err < 0) ? -err : err);
        pmag = mul_shr(kp, eabs, 32, cap);
        dmag = mul_shr(kd, rmag, 32, cap);
        pv = (err < 0) ? -longint'(pmag) : longint'(pmag);
        dv = (diff < 0) ? -longint'(dmag) : longint'(dmag);
        outv = pv + dv;
        if (outv < 0) outv = 0;
        if (outv > 65536) outv = 65536;
        last_error = int'(err);
        last_deploy = 17'(outv);
        angle = 64'(ANGLE_STOW) - ((64'(ANGLE_SPAN) * 64'(outv) + 64'(ROUND_HALF)) >> 16);
      end

      gate = it.act && ax <= longint'(ACCEL_LIM) && ax >= -longint'(ACCEL_LIM);
      r.kp = kp[63:16];
      r.kd = kd[63:16];
      r.ang = angle[15:0];
      r.app = gate ? angle[15:0] : ANGLE_STOW;
      r.gate = gate;
      return r;
    endfunction

    function void note_input(sample_t it);
      cmd_q.push_back(predict(it));
    endfunction

    function void check_result(command_t got);
      command_t want;
      if (cmd_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = cmd_q.pop_front();
      if (got.kp !== want.kp) begin
        $display("%0t: gain_p expected %h actual %h", $time, want.kp, got.kp);
        errors++;
      end
      if (got.kd !== want.kd) begin
        $display("%0t: gain_d expected %h actual %h", $time, want.kd, got.kd);
        errors++;
      end
      if (got.ang !== want.ang) begin
        $display("%0t: computed_angle expected %0d actual %0d", $time, want.ang, got.ang);
        errors++;
      end
      if (got.app !== want.app) begin
        $display("%0t: applied_angle expected %0d actual %0d", $time, want.app, got.app);
        errors++;
      end
      if (got.gate !== want.gate) begin
        $display("%0t: gate_open expected %b actual %b", $time, want.gate, got.gate);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [24:0] pressure_i;
  logic [23:0] temperature_i;
  logic [31:0] altitude_i, velocity_i, tick_ms_i, accel_x_i;
  logic        active_i;
  logic [47:0] gain_p_o, gain_d_o;
  logic [15:0] computed_angle_o, applied_angle_o;
  logic        gate_open_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [30:0] cfg_data_i;

  brake_scoreboard sb;
  int unsigned rx_hold, rx_gap, quiet_cycles;
  bit          rx_idle_on, tx_idle_on;
  logic [31:0] tx_tick;

  airbrake_apogee_pd_controller u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
  endfunction

  // receiver stall pattern, long hold-offs counted here
  initial begin
    out_stall_i = 1'b0;
    rx_gap = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        out_stall_i = 1'b1;
        rx_hold--;
      end else if (rx_gap != 0) begin
        out_stall_i = 1'b1;
        rx_gap--;
      end else begin
        out_stall_i = 1'b0;
        if (rx_idle_on && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({gain_p_o, gain_d_o, computed_angle_o, applied_angle_o, gate_open_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAIL airbrake_apogee_pd_controller");
      $finish;
    end
  end

  task automatic send(sample_t it);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    {pressure_i, temperature_i, altitude_i, velocity_i, tick_ms_i, active_i, accel_x_i} = it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
  endtask

  task automatic tx_pause(int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    tx_pause(1);
    while (sb.cmd_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_fixed(logic [24:0] p, logic [31:0] v, logic [31:0] tk, logic act,
                            logic [31:0] ax);
    sample_t it;
    it = '{pres: p, temp: 24'd0, alt: 32'd200540160, vel: v, tick: tk, act: act, ax: ax};
    send(it);
  endtask

  function automatic sample_t rand_sample();
    sample_t it;
    int      sel;
    sel = $urandom_range(0, 9);
    it.pres = (sel == 0) ? 25'd0 : (sel == 1) ? '1 : (sel == 2) ? 25'($urandom)
            : 25'($urandom_range(20000 * 256, 110000 * 256));
    it.temp = ($urandom_range(0, 7) == 0) ? 24'($urandom)
            : 24'($urandom_range(0, 80 * 65536) - 40 * 65536);
    it.alt = ($urandom_range(0, 7) == 0) ? $urandom
           : 32'(sb.cfg[5]) + 32'($urandom_range(0, 1200 * 65536)) - 32'(900 * 65536);
    sel = $urandom_range(0, 9);
    if (sel == 0) it.vel = 32'($urandom_range(0, 131070)) - 32'd65535;
    else if (sel == 1) it.vel = $urandom;
    else if (sel == 2) it.vel = -32'($urandom_range(65536, 340 * 65536));
    else it.vel = 32'($urandom_range(65536, 340 * 65536));
    sel = $urandom_range(0, 9);
    if (sel == 0) tx_tick = tx_tick;
    else if (sel == 1) tx_tick = $urandom;
    else if (sel == 2) tx_tick = tx_tick - 32'($urandom_range(1, 50));
    else tx_tick = tx_tick + 32'($urandom_range(1, 60));
    it.tick = tx_tick;
    it.act = ($urandom_range(0, 6) != 0);
    sel = $urandom_range(0, 9);
    if (sel == 0) it.ax = $urandom_range(0, 1) ? ACCEL_LIM : -ACCEL_LIM;
    else if (sel == 1) it.ax = $urandom_range(0, 1) ? ACCEL_LIM + 1 : -(ACCEL_LIM + 1);
    else if (sel == 2) it.ax = $urandom;
    else it.ax = 32'($urandom_range(0, 80 * 65536)) - 32'(40 * 65536);
    return it;
  endfunction

  task automatic set_phase(int ph);
    case (ph)
      0: begin
        cfg_write(REG_SOS, SOS_RST);   cfg_write(REG_MASS, MASS_RST);
        cfg_write(REG_AREA, AREA_RST); cfg_write(REG_GRAV, GRAV_RST);
        cfg_write(REG_ZETA, ZETA_RST); cfg_write(REG_TARGET, TARGET_RST);
        cfg_write(REG_FLOOR, FLOOR_RST);
      end
      1: begin
        cfg_write(REG_SOS, 31'd65536); cfg_write(REG_MASS, 31'd65536);
        cfg_write(REG_AREA, 31'd1);    cfg_write(REG_GRAV, 31'd0);
        cfg_write(REG_ZETA, 31'd0);    cfg_write(REG_TARGET, 31'd0);
        cfg_write(REG_FLOOR, 31'd0);
      end
      2: begin
        cfg_write(REG_SOS, 31'd33554432); cfg_write(REG_MASS, 31'd65536000);
        cfg_write(REG_AREA, 31'd65536);   cfg_write(REG_GRAV, 31'd1310720);
        cfg_write(REG_ZETA, 31'd262144);  cfg_write(REG_TARGET, 31'd2147483647);
        cfg_write(REG_FLOOR, 31'd131072);
      end
      3: begin
        // no speed of sound, defaults in the other registers
        cfg_write(REG_SOS, 31'd0);        cfg_write(REG_MASS, MASS_RST);
        cfg_write(REG_AREA, AREA_RST);    cfg_write(REG_GRAV, GRAV_RST);
        cfg_write(REG_ZETA, ZETA_RST);    cfg_write(REG_TARGET, TARGET_RST);
        cfg_write(REG_FLOOR, FLOOR_RST);
      end
      4: begin
        cfg_write(REG_SOS, SOS_RST); cfg_write(REG_MASS, 31'd0);
        cfg_write(REG_GRAV, 31'd0);
        cfg_write(REG_NONE, $urandom);
      end
      5: begin
        cfg_write(REG_MASS, MASS_RST); cfg_write(REG_GRAV, 31'd0);
        cfg_write(REG_AREA, 31'd1);    cfg_write(REG_FLOOR, 31'd0);
      end
      default: begin
        for (int i = 0; i < 7; i++) cfg_write(3'(i), 31'($urandom));
      end
    endcase
  endtask

  initial begin
    sample_t it;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    {pressure_i, temperature_i, altitude_i, velocity_i, tick_ms_i, active_i, accel_x_i} = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_SOS;
    cfg_data_i = '0;
    rx_hold = 0;
    rx_idle_on = 1'b0;
    tx_idle_on = 1'b0;
    quiet_cycles = 0;
    tx_tick = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, slow vehicle, equal ticks, gate edges
    send_fixed(25'd25939200, 32'd0, 32'd0, 1'b1, 32'd0);
    send_fixed(25'd25939200, 32'd65535, 32'd20, 1'b1, 32'd0);
    send_fixed(25'd25939200, -32'd65535, 32'd40, 1'b1, 32'd0);
    send_fixed(25'd25939200, 32'd65536, 32'd60, 1'b1, ACCEL_LIM);
    send_fixed(25'd25939200, -32'd65536, 32'd60, 1'b1, -ACCEL_LIM);
    send_fixed(25'd25939200, 32'd13107200, 32'd80, 1'b1, ACCEL_LIM + 1);
    send_fixed(25'd25939200, 32'd13107200, 32'd100, 1'b1, -(ACCEL_LIM + 1));
    send_fixed(25'd25939200, 32'h7FFFFFFF, 32'd120, 1'b1, 32'h80000000);
    send_fixed(25'd25939200, 32'h80000000, 32'd140, 1'b1, 32'h7FFFFFFF);
    send_fixed(25'd0, 32'd13107200, 32'd160, 1'b1, 32'd0);
    send_fixed('1, 32'd13107200, 32'hFFFFFFFF, 1'b0, 32'd0);
    send_fixed(25'd25939200, 32'd6553600, 32'd5, 1'b1, 32'd0);
    send_fixed(25'd25939200, 32'd6553600, 32'd5, 1'b1, 32'd0);
    it = '{pres: '1, temp: 24'h800000, alt: 32'h80000000, vel: 32'd19660800,
           tick: 32'd30, act: 1'b1, ax: 32'd0};
    send(it);
    it = '{pres: '1, temp: 24'h7FFFFF, alt: 32'h7FFFFFFF, vel: 32'd19660800,
           tick: 32'd50, act: 1'b1, ax: 32'd0};
    send(it);
    it = '{pres: 25'd25939200, temp: 24'd0, alt: 32'd0, vel: 32'd22478848,
           tick: 32'd70, act: 1'b1, ax: 32'd0};
    send(it);
    tx_tick = 32'd70;
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_phase(ph);
      rx_idle_on = (ph % 3 != 2);
      tx_idle_on = (ph % 4 != 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == 40) begin
          // receiver holds off while items keep coming
          rx_hold = 4000;
          for (int k = 0; k < 6; k++) send(rand_sample());
        end
        if (ph == 2 && n == 60) drain();
        send(rand_sample());
        if (tx_idle_on && $urandom_range(0, 2) == 0) tx_pause(pick_gap());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.cmd_q.size() == 0) begin
      $display("PASS airbrake_apogee_pd_controller");
    end else begin
      $display("FAIL airbrake_apogee_pd_controller");
    end
    $finish;
  end

endmodule
